>>> sv/wnmd_pkg.sv
`timescale 1ns / 1ps

package wnmd_pkg;

   // Sample width; the window bounds and the spread follow it.
   localparam int SAMPLE_BITS = 16;

   localparam int LEN_W       = 8;
   localparam int THRESH_W    = 16;
   localparam int WEIGHT_W    = 7;
   localparam int NOISE_W     = 20;
   localparam int SMOOTH_W    = 16;
   localparam int PHASE_W     = 2;
   localparam int CMP_W       = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

   // Smoothing sum: at most 100 * (2^SMOOTH_W - 1), below 2^23.
   localparam int ACC_W       = SMOOTH_W + WEIGHT_W;

   // Divide by 100 as a multiply by ceil(2^30 / 100); exact for every ACC_W value.
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
   localparam int PROD_W      = ACC_W + RECIP_W;

   localparam logic [LEN_W-1:0]    WINDOW_CAP  = LEN_W'(253);
   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(100);

   // Reset values of the configuration registers.
   localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RST    = LEN_W'(100);
   localparam logic [THRESH_W-1:0] MOVING_THRESHOLD_RST = THRESH_W'(40);
   localparam logic [WEIGHT_W-1:0] AVERAGE_WEIGHT_RST   = WEIGHT_W'(10);
   localparam logic [NOISE_W-1:0]  STARTUP_LIMIT_RST    = NOISE_W'(100);

   // CSR map: register i at byte address 4*i.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MOVING_THRESHOLD = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_AVERAGE_WEIGHT   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_STARTUP_LIMIT    = 2'd3;

   // Phase reported with each result.
   localparam logic [PHASE_W-1:0] PHASE_ACCUM   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_EVAL    = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_PUBLISH = 2'd2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

endpackage

>>> sv/wnmd_req_if.sv
`timescale 1ns / 1ps

interface wnmd_req_if;
   import wnmd_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> sv/wnmd_rsp_if.sv
`timescale 1ns / 1ps

interface wnmd_rsp_if;
   import wnmd_pkg::*;

   logic               valid;
   logic               ready;
   logic               moving;
   logic [NOISE_W-1:0] noise_level;
   logic               startup_done;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output moving, output noise_level, output startup_done,
                   output phase, input ready);
   modport sink   (input valid, input moving, input noise_level, input startup_done,
                   input phase, output ready);
endinterface

>>> sv/window_noise_motion_detector.sv
// Window noise and motion detector.
// req_chan carries one signed sensor sample per transfer; rsp_chan returns
// exactly one result per sample: moving flag, published noise level,
// startup-done flag and the phase code of that sample (accumulate, evaluate,
// publish). Results leave in input order.
// The result of a sample is valid the cycle after its transfer.
// Throughput: one sample per cycle; the output register is the only stage,
// so req_chan.ready is high whenever that register is empty or being drained.
// If the receiver stalls, the pending result holds and req_chan.ready drops
// until rsp_chan.ready returns; nothing is lost or repeated.
// The divide by 100 of the smoothing step runs after the evaluate sample in a
// background stage; the next sample sees the finished value.
// Reset (synchronous, active high) loads the register defaults, zeroes the
// window bounds, tick count, average and flags, and empties the output.
// CSR writes land on the access cycle (psel, penable, pwrite); write them
// only while the block is idle. Reads return the register value.
`timescale 1ns / 1ps

module window_noise_motion_detector (
   input  logic                          clock,
   input  logic                          reset,
   wnmd_req_if.sink                      req_chan,
   wnmd_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wnmd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wnmd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wnmd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import wnmd_pkg::*;

   // Configuration registers.
   logic [LEN_W-1:0]    window_length_ff;
   logic [THRESH_W-1:0] moving_threshold_ff;
   logic [WEIGHT_W-1:0] average_weight_ff;
   logic [NOISE_W-1:0]  startup_limit_ff;

   // Window and noise state.
   logic [LEN_W-1:0]    tick_count_ff, tick_count_in;
   sample_type          window_min_ff, window_min_in;
   sample_type          window_max_ff, window_max_in;
   logic [SMOOTH_W-1:0] smoothed_ff, smoothed_in;
   logic                moving_ff, moving_in;
   logic [NOISE_W-1:0]  published_ff, published_in;
   logic                startup_ff, startup_in;

   // Divide stage: smoothing sum waiting for its divide by 100.
   logic                pending_ff, pending_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;

   logic                req_xfer;
   logic                csr_write;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [LEN_W-1:0]    len;
   logic [WEIGHT_W-1:0] weight;
   logic [WEIGHT_W-1:0] weight_inv;
   logic signed [SAMPLE_BITS:0] diff;
   logic [SAMPLE_BITS-1:0] spread;
   logic                quiet;
   logic [PROD_W-1:0]   recip_prod;
   logic [SMOOTH_W-1:0] smoothed_view;
   logic [NOISE_W-1:0]  noise_ten;

   // ---------------------------------------------------------------
   // CSR port: always ready, write on the access cycle.
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[REG_IDX_W+1:2];

   always_comb begin
      case (reg_idx)
         REG_WINDOW_LENGTH:    prdata = CSR_DATA_W'(window_length_ff);
         REG_MOVING_THRESHOLD: prdata = CSR_DATA_W'(moving_threshold_ff);
         REG_AVERAGE_WEIGHT:   prdata = CSR_DATA_W'(average_weight_ff);
         REG_STARTUP_LIMIT:    prdata = CSR_DATA_W'(startup_limit_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff    <= WINDOW_LENGTH_RST;
         moving_threshold_ff <= MOVING_THRESHOLD_RST;
         average_weight_ff   <= AVERAGE_WEIGHT_RST;
         startup_limit_ff    <= STARTUP_LIMIT_RST;
      end else if (csr_write) begin
         case (reg_idx)
            REG_WINDOW_LENGTH:    window_length_ff    <= pwdata[LEN_W-1:0];
            REG_MOVING_THRESHOLD: moving_threshold_ff <= pwdata[THRESH_W-1:0];
            REG_AVERAGE_WEIGHT:   average_weight_ff   <= pwdata[WEIGHT_W-1:0];
            REG_STARTUP_LIMIT:    startup_limit_ff    <= pwdata[NOISE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: accept whenever the output register is free or drains.
   // ---------------------------------------------------------------
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // Clamp the window length and the weight to their legal ranges.
   assign len        = (window_length_ff > WINDOW_CAP) ? WINDOW_CAP : window_length_ff;
   assign weight     = (average_weight_ff > WEIGHT_FULL) ? WEIGHT_FULL : average_weight_ff;
   assign weight_inv = WEIGHT_FULL - weight;

   // Spread of the window; min never exceeds max, so it is non-negative.
   assign diff   = (SAMPLE_BITS+1)'(window_max_ff) - (SAMPLE_BITS+1)'(window_min_ff);
   assign spread = diff[SAMPLE_BITS-1:0];
   assign quiet  = CMP_W'(spread) < CMP_W'(moving_threshold_ff);

   // Finish the divide by 100 of a pending smoothing sum.
   assign recip_prod    = PROD_W'(acc_ff) * PROD_W'(RECIP_MULT);
   assign smoothed_view = pending_ff ? recip_prod[RECIP_SHIFT +: SMOOTH_W] : smoothed_ff;
   // Times ten as two shifted copies.
   assign noise_ten     = (NOISE_W'(smoothed_view) << 3) + (NOISE_W'(smoothed_view) << 1);

   always_comb begin
      tick_count_in = tick_count_ff;
      window_min_in = window_min_ff;
      window_max_in = window_max_ff;
      moving_in     = moving_ff;
      published_in  = published_ff;
      startup_in    = startup_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      // Retire the divide stage every cycle; an evaluate below restarts it.
      pending_in    = 1'b0;
      smoothed_in   = smoothed_view;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         if (tick_count_ff < len) begin
            // Accumulate: widen the window bounds.
            if (req_chan.sample < window_min_ff) window_min_in = req_chan.sample;
            if (req_chan.sample > window_max_ff) window_max_in = req_chan.sample;
            tick_count_in = tick_count_ff + LEN_W'(1);
            phase_in      = PHASE_ACCUM;
         end else if (tick_count_ff == len) begin
            // Evaluate: decide motion, fold a quiet spread into the average.
            tick_count_in = tick_count_ff + LEN_W'(1);
            phase_in      = PHASE_EVAL;
            if (quiet) begin
               moving_in = 1'b0;
               if (smoothed_ff == '0) begin
                  smoothed_in = SMOOTH_W'(spread);
               end else begin
                  acc_in     = ACC_W'(smoothed_ff) * ACC_W'(weight)
                             + ACC_W'(SMOOTH_W'(spread)) * ACC_W'(weight_inv);
                  pending_in = 1'b1;
               end
            end else begin
               moving_in = 1'b1;
            end
         end else begin
            // Publish: ten times the average, latch startup, restart window.
            published_in  = noise_ten;
            if (noise_ten < startup_limit_ff) startup_in = 1'b1;
            tick_count_in = '0;
            window_min_in = req_chan.sample;
            window_max_in = req_chan.sample;
            phase_in      = PHASE_PUBLISH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         window_min_ff <= '0;
         window_max_ff <= '0;
         smoothed_ff   <= '0;
         moving_ff     <= 1'b0;
         published_ff  <= '0;
         startup_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PHASE_ACCUM;
      end else begin
         tick_count_ff <= tick_count_in;
         window_min_ff <= window_min_in;
         window_max_ff <= window_max_in;
         smoothed_ff   <= smoothed_in;
         moving_ff     <= moving_in;
         published_ff  <= published_in;
         startup_ff    <= startup_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
      end
   end

   // Smoothing sum carries no reset; pending_ff qualifies it.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Result fields mirror the state left by the last sample.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.moving       = moving_ff;
   assign rsp_chan.noise_level  = published_ff;
   assign rsp_chan.startup_done = startup_ff;
   assign rsp_chan.phase        = phase_ff;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import wnmd_pkg::*;

   typedef struct packed {
      logic               moving;
      logic [NOISE_W-1:0] noise_level;
      logic               startup_done;
      logic [PHASE_W-1:0] phase;
   } detector_result_type;

   // Idle cycles in a row, with no transfer on either channel, before the run is abandoned.
   localparam int STALL_LIMIT     = 4000;
   localparam int LONG_HOLDOFF    = 400;
   localparam int ITEM_TARGET     = 1250;
   localparam int MAX_PRINTED     = 100;
   // Cap per register setting, so the first phases cannot use up the item budget.
   localparam int MAX_PHASE_ITEMS = 300;

   logic clock;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   wnmd_req_if req_if ();
   wnmd_rsp_if rsp_if ();

   window_noise_motion_detector DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Samples waiting to be driven, and results predicted for accepted samples.
   sample_type          pending_samples[$];
   detector_result_type predicted_results[$];

   // Predictor copy of the register file.
   logic [LEN_W-1:0]    cfg_len;
   logic [THRESH_W-1:0] cfg_thresh;
   logic [WEIGHT_W-1:0] cfg_weight;
   logic [NOISE_W-1:0]  cfg_limit;

   // Predictor copy of the detector state.
   logic [LEN_W-1:0]              st_ticks;
   logic signed [SAMPLE_BITS-1:0] st_min;
   logic signed [SAMPLE_BITS-1:0] st_max;
   logic [SMOOTH_W-1:0]           st_smooth;
   logic                          st_moving;
   logic [NOISE_W-1:0]            st_published;
   logic                          st_startup;

   int errors;
   int raised_cnt;
   int taken_cnt;
   int result_cnt;
   int queued_cnt;
   int idle_cycles;
   int gap_left;
   int stall_left;
   int n_phases;
   int n_evals;
   int n_moving;
   int n_smoothed;
   int n_publish;
   int n_csr_reads;
   bit tx_free;
   bit rx_free;
   bit long_holdoff_req;

   // Clock: 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      if (errors < MAX_PRINTED)
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Advance the predicted detector by one sample and return the result it causes.
   function automatic detector_result_type advance_detector(sample_type s);
      int                  len;
      int                  spread;
      int                  w;
      int                  acc;
      detector_result_type r;
      len = (cfg_len > WINDOW_CAP) ? int'(WINDOW_CAP) : int'(cfg_len);
      if (int'(st_ticks) < len) begin
         // Accumulate: widen the window bounds.
         if (s < st_min) st_min = s;
         if (s > st_max) st_max = s;
         st_ticks = st_ticks + LEN_W'(1);
         r.phase = PHASE_ACCUM;
      end else if (int'(st_ticks) == len) begin
         // Evaluate: the sample itself is not part of the window.
         spread = int'(st_max) - int'(st_min);
         st_ticks = st_ticks + LEN_W'(1);
         n_evals++;
         if (spread < int'(cfg_thresh)) begin
            st_moving = 1'b0;
            n_smoothed++;
            if (st_smooth == '0) begin
               // First average: take the spread as is.
               st_smooth = SMOOTH_W'(spread);
            end else begin
               w = (cfg_weight > WEIGHT_FULL) ? int'(WEIGHT_FULL) : int'(cfg_weight);
               acc = int'(st_smooth) * w + spread * (100 - w);
               st_smooth = SMOOTH_W'(acc / 100);
            end
         end else begin
            st_moving = 1'b1;
            n_moving++;
         end
         r.phase = PHASE_EVAL;
      end else begin
         // Publish and restart the window from this sample.
         st_published = NOISE_W'(int'(st_smooth) * 10);
         if (st_published < cfg_limit) st_startup = 1'b1;
         st_ticks = '0;
         st_min = s;
         st_max = s;
         n_publish++;
         r.phase = PHASE_PUBLISH;
      end
      r.moving       = st_moving;
      r.noise_level  = st_published;
      r.startup_done = st_startup;
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_WINDOW_LENGTH:    return CSR_DATA_W'(cfg_len);
         REG_MOVING_THRESHOLD: return CSR_DATA_W'(cfg_thresh);
         REG_AVERAGE_WEIGHT:   return CSR_DATA_W'(cfg_weight);
         default:              return CSR_DATA_W'(cfg_limit);
      endcase
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Driver, accept side: predict on every input transfer.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         predicted_results.push_back(advance_detector(req_if.sample));
         taken_cnt++;
      end
   end

   // Driver, drive side: hold the item until it transfers, then advance.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || taken_cnt == raised_cnt) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            req_if.sample <= pending_samples.pop_front();
            req_if.valid  <= 1'b1;
            raised_cnt++;
            gap_left = tx_free ? 0 : pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (long_holdoff_req) begin
            long_holdoff_req = 1'b0;
            stall_left = LONG_HOLDOFF;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!rx_free && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
            rsp_if.ready <= (stall_left == 0);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      detector_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_cnt++;
         if (predicted_results.size() == 0) begin
            report_mismatch("unexpected result, count", result_cnt, taken_cnt);
         end else begin
            want = predicted_results.pop_front();
            if (rsp_if.moving !== want.moving)
               report_mismatch("moving", rsp_if.moving, want.moving);
            if (rsp_if.noise_level !== want.noise_level)
               report_mismatch("noise_level", rsp_if.noise_level, want.noise_level);
            if (rsp_if.startup_done !== want.startup_done)
               report_mismatch("startup_done", rsp_if.startup_done, want.startup_done);
            if (rsp_if.phase !== want.phase)
               report_mismatch("phase", rsp_if.phase, want.phase);
         end
      end
   end

   // Watchdog: abandon the run after too long without any transfer.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d idle cycles, %0d results pending",
                  idle_cycles, predicted_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // Mirror the write into the predictor at the edge where it lands.
      case (idx)
         REG_WINDOW_LENGTH:    cfg_len    = data[LEN_W-1:0];
         REG_MOVING_THRESHOLD: cfg_thresh = data[THRESH_W-1:0];
         REG_AVERAGE_WEIGHT:   cfg_weight = data[WEIGHT_W-1:0];
         default:              cfg_limit  = data[NOISE_W-1:0];
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(logic [REG_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] want;
      want = reg_value(idx);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      n_csr_reads++;
      if (prdata !== want)
         report_mismatch($sformatf("register %0d readback", idx), prdata, want);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write all four registers (stray upper bits now and then) and read them back.
   task automatic program_detector(int len, int thresh, int weight, int limit);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      csr_write(REG_WINDOW_LENGTH,    CSR_DATA_W'(len)    | (junk & ~32'h0000_00FF));
      csr_write(REG_MOVING_THRESHOLD, CSR_DATA_W'(thresh) | (junk & ~32'h0000_FFFF));
      csr_write(REG_AVERAGE_WEIGHT,   CSR_DATA_W'(weight) | (junk & ~32'h0000_007F));
      csr_write(REG_STARTUP_LIMIT,    CSR_DATA_W'(limit)  | (junk & ~32'h000F_FFFF));
      csr_check(REG_WINDOW_LENGTH);
      csr_check(REG_MOVING_THRESHOLD);
      csr_check(REG_AVERAGE_WEIGHT);
      csr_check(REG_STARTUP_LIMIT);
      n_phases++;
   endtask

   // Wait until every sample has transferred and every result has arrived.
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_if.valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic push_sample(int v);
      pending_samples.push_back(sample_type'(v));
      queued_cnt++;
   endtask

   // Noisy reading around a center; a share of wild full-range values.
   function automatic int noisy_sample(int center, int amp, int wild_pct);
      int v;
      int r;
      r = $urandom_range(0, 99);
      if (r < wild_pct / 4)
         return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      if (r < wild_pct)
         return int'($urandom_range(0, 65535)) - 32768;
      v = center + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   initial begin
      int phase_idx;
      int len;
      int thresh;
      int weight;
      int limit;
      int windows;
      int items_n;
      int center;
      int amp;
      int amp_max;
      int wild;
      int r;

      // Drive every input to a known value from time zero.
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      rsp_if.ready     = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      tx_free          = 1'b0;
      rx_free          = 1'b0;
      long_holdoff_req = 1'b0;
      gap_left         = 0;
      stall_left       = 0;

      cfg_len      = WINDOW_LENGTH_RST;
      cfg_thresh   = MOVING_THRESHOLD_RST;
      cfg_weight   = AVERAGE_WEIGHT_RST;
      cfg_limit    = STARTUP_LIMIT_RST;
      st_ticks     = '0;
      st_min       = '0;
      st_max       = '0;
      st_smooth    = '0;
      st_moving    = 1'b0;
      st_published = '0;
      st_startup   = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers must come out of reset at their defaults.
      csr_check(REG_WINDOW_LENGTH);
      csr_check(REG_MOVING_THRESHOLD);
      csr_check(REG_AVERAGE_WEIGHT);
      csr_check(REG_STARTUP_LIMIT);

      // Zero after reset: all-positive first window still spans down to zero,
      // then the first average is taken directly. Second window spans full scale.
      program_detector(3, 65535, 0, 655350);
      push_sample(5);
      push_sample(9);
      push_sample(7);
      push_sample(-32768);
      push_sample(32767);
      push_sample(-32768);
      push_sample(32767);
      push_sample(0);
      push_sample(1);
      push_sample(-1);
      wait_drained();

      // Window of zero with the weight beyond full scale.
      program_detector(0, 65535, 127, 0);
      push_sample(100);
      push_sample(-100);
      push_sample(3);
      push_sample(3);
      wait_drained();

      // Length lowered mid-window: the next sample publishes and restarts.
      program_detector(5, 40, 50, 1048575);
      push_sample(10);
      push_sample(30);
      push_sample(20);
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, CSR_DATA_W'(1));
      csr_check(REG_WINDOW_LENGTH);
      push_sample(-5);
      push_sample(-6);
      push_sample(-2);
      push_sample(-4);
      wait_drained();

      // Random phases: new settings each time, mostly well-formed windows.
      phase_idx = 0;
      while (queued_cnt < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 60)      len = $urandom_range(0, 8);
         else if (r < 85) len = $urandom_range(9, 40);
         else if (r < 95) len = $urandom_range(41, 120);
         else             len = $urandom_range(253, 255);

         r = $urandom_range(0, 99);
         if (r < 10)      thresh = 0;
         else if (r < 20) thresh = 65535;
         else if (r < 70) thresh = $urandom_range(1, 300);
         else             thresh = $urandom_range(0, 65535);

         r = $urandom_range(0, 99);
         if (r < 15)      weight = 0;
         else if (r < 30) weight = 100;
         else if (r < 40) weight = $urandom_range(101, 127);
         else             weight = $urandom_range(1, 99);

         r = $urandom_range(0, 99);
         if (r < 10)      limit = 0;
         else if (r < 20) limit = 655350;
         else if (r < 25) limit = 1048575;
         else             limit = $urandom_range(0, 3000);

         program_detector(len, thresh, weight, limit);

         windows = (len > 120) ? 1 : $urandom_range(2, 6);
         items_n = windows * (((len > 253) ? 253 : len) + 2) + $urandom_range(0, 3);
         if (items_n > MAX_PHASE_ITEMS) items_n = MAX_PHASE_ITEMS;
         if (phase_idx == 2 && items_n < 150) items_n = 150;

         center  = int'($urandom_range(0, 65535)) - 32768;
         amp_max = (thresh > 16000) ? 16000 : thresh;
         amp     = int'($urandom_range(0, amp_max)) / 2;
         wild    = ($urandom_range(0, 3) == 0) ? 40 : 8;

         tx_free = (phase_idx % 7 == 5) || (phase_idx == 2);
         rx_free = (phase_idx % 7 == 5);

         // Long receiver hold-off while the sender keeps offering.
         if (phase_idx == 2) long_holdoff_req = 1'b1;

         for (int i = 0; i < items_n; i++) begin
            // Pause the sender halfway until every result is back.
            if (phase_idx == 4 && i == items_n / 2) wait_drained();
            push_sample(noisy_sample(center, amp, wild));
         end
         wait_drained();
         phase_idx++;
      end

      tx_free = 1'b0;
      rx_free = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d samples over %0d register settings, %0d readbacks",
               queued_cnt, n_phases, n_csr_reads);
      $display("Windows: %0d evaluated, %0d moving, %0d averaged, %0d published",
               n_evals, n_moving, n_smoothed, n_publish);
      if (errors == 0 && predicted_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Errors: %0d, results still pending: %0d", errors,
                  predicted_results.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
